### hdl/lsw_pkg.sv
// Package for the two-wire LED segment writer.
// Holds request codes, sequencer phase type, frame constants and the character encoder.
// No dependencies.
package lsw_pkg;

    localparam int unsigned SHOWN_DIGITS = 4;

    localparam logic [2:0] REQ_TICK    = 3'd0;
    localparam logic [2:0] REQ_RAW     = 3'd1;
    localparam logic [2:0] REQ_CHAR    = 3'd2;
    localparam logic [2:0] REQ_SHOW    = 3'd3;
    localparam logic [2:0] REQ_REFRESH = 3'd4;

    localparam logic [7:0] CMD_DATA_FIXED = 8'h44;
    localparam logic [7:0] CMD_DATA_AUTO  = 8'h40;
    localparam logic [7:0] CMD_ADDR       = 8'hC0;
    localparam logic [7:0] CMD_DISPLAY_ON = 8'h88;
    localparam logic [7:0] SEG_DOT        = 8'h80;

    localparam logic [2:0] BRIGHTNESS_RESET = 3'd7;

    typedef enum logic [1:0] {
        PH_START,
        PH_BYTE,
        PH_ACK,
        PH_STOP
    } phase_t;

    typedef logic [7:0] seg_table_t [0:38];

    localparam seg_table_t SEG_TABLE = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
        8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h76, 8'h06, 8'h1E,
        8'h76, 8'h38, 8'h55, 8'h54, 8'h3F, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78,
        8'h3E, 8'h1C, 8'h2A, 8'h76, 8'h6E, 8'h5B, 8'h00, 8'h40, 8'h63
    };

    localparam logic [5:0] SEG_BLANK = 6'd36;
    localparam logic [5:0] SEG_DASH  = 6'd37;
    localparam logic [5:0] SEG_STAR  = 6'd38;

    function automatic logic [7:0] encode_ascii(input logic [7:0] c);
        logic [7:0] idx;
        idx = {2'b00, SEG_BLANK};
        if (c == 8'd32) begin
            idx = {2'b00, SEG_BLANK};
        end else if (c == 8'd42) begin
            idx = {2'b00, SEG_STAR};
        end else if (c == 8'd45) begin
            idx = {2'b00, SEG_DASH};
        end else if (c >= 8'd65 && c <= 8'd90) begin
            idx = c - 8'd55;
        end else if (c >= 8'd97 && c <= 8'd122) begin
            idx = c - 8'd87;
        end else if (c >= 8'd48 && c <= 8'd57) begin
            idx = c - 8'd48;
        end
        return SEG_TABLE[idx[5:0]];
    endfunction

endpackage

### hdl/led_segment_two_wire_writer_unit.sv
// Top level of the two-wire LED segment writer: request decode, pin sequencer, result register.
// Depends on lsw_pkg.
//
// Usage:
//   Input channel s_*: one transfer per item. s_tuser carries the request kind
//   (tick, raw write, character write, show, refresh); s_tdata the arguments.
//   A request loads up to three frames; each following tick moves the pins by
//   one step. A request that arrives while a sequence is running is dropped and
//   flagged in the result.
//   Output channel m_*: exactly one result transfer per input transfer, giving
//   pin levels after the item, busy and rejected flags.
//   The result is registered: it is valid in the cycle after the input transfer.
//   Throughput: one item per cycle while m_tready is high; the whole step is a
//   single pass between the sequencer state and the result register.
//   Stall: while m_tready is low with a result held, s_tready is low; a new item
//   is taken in the same cycle the held result is taken.
//   Configuration: cfg_we writes cfg_wdata into brightness; the user must write it
//   only while idle, the block does not enforce it. Reset: synchronous, active low;
//   pins low, sequencer idle, brightness 7, no result pending.
module led_segment_two_wire_writer_unit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] req_type
    input  logic [2:0]  s_tuser,
    // [2:0] position, [10:3] raw_segments, [18:11] char_first, [26:19] char_second,
    // [34:27] char_third, [42:35] char_fourth, [43] dot_on, [44] colon_on, [47:45] zero
    input  logic [47:0] s_tdata,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] clock_level, [1] data_level, [2] busy_res, [3] rejected, [7:4] zero
    output logic [7:0]  m_tdata
);
    import lsw_pkg::*;

    logic [2:0] req_type;
    logic [2:0] position;
    logic [7:0] raw_segments;
    logic [7:0] chars [0:3];
    logic       dot_on;
    logic       colon_on;
    logic       s_accept;
    logic       is_request;

    logic [2:0] brightness_reg;
    logic       clock_pin_reg,  clock_pin_next;
    logic       data_pin_reg,   data_pin_next;
    logic       active_reg,     active_next;
    logic [1:0] frame_index_reg, frame_index_next;
    logic [2:0] byte_index_reg,  byte_index_next;
    logic [2:0] bit_reg,         bit_next;
    logic [1:0] sub_reg,         sub_next;
    phase_t     phase_reg,       phase_next;
    logic       rejected_next;

    logic [7:0] byte_store_reg  [0:7];
    logic [7:0] byte_store_next [0:7];
    logic [2:0] frame_len_reg   [0:2];
    logic [2:0] frame_len_next  [0:2];
    logic       store_we;

    logic [7:0] cur_byte;
    logic [2:0] byte_inc;
    logic [7:0] char_seg;

    logic       m_tvalid_reg;
    logic [3:0] result_reg;

    assign req_type     = s_tuser;
    assign position     = s_tdata[2:0];
    assign raw_segments = s_tdata[10:3];
    assign chars[0]     = s_tdata[18:11];
    assign chars[1]     = s_tdata[26:19];
    assign chars[2]     = s_tdata[34:27];
    assign chars[3]     = s_tdata[42:35];
    assign dot_on       = s_tdata[43];
    assign colon_on     = s_tdata[44];

    assign s_tready   = !m_tvalid_reg || m_tready;
    assign s_accept   = s_tvalid && s_tready;
    assign is_request = (req_type == REQ_RAW) || (req_type == REQ_CHAR)
                     || (req_type == REQ_SHOW) || (req_type == REQ_REFRESH);

    always_comb begin
        unique case (frame_index_reg)
            2'd0:    cur_byte = byte_store_reg[0];
            2'd1:    cur_byte = byte_store_reg[3'(byte_index_reg + 3'd1)];
            default: cur_byte = CMD_DISPLAY_ON | {5'd0, brightness_reg};
        endcase
    end

    assign byte_inc = byte_index_reg + 3'd1;
    assign char_seg = encode_ascii(chars[0]) | (dot_on ? SEG_DOT : 8'h00);

    // Sequencer and request loader
    always_comb begin
        clock_pin_next   = clock_pin_reg;
        data_pin_next    = data_pin_reg;
        active_next      = active_reg;
        frame_index_next = frame_index_reg;
        byte_index_next  = byte_index_reg;
        bit_next         = bit_reg;
        sub_next         = sub_reg;
        phase_next       = phase_reg;
        rejected_next    = 1'b0;
        store_we         = 1'b0;
        byte_store_next  = byte_store_reg;
        frame_len_next   = frame_len_reg;

        if (req_type == REQ_TICK) begin
            if (active_reg) begin
                unique case (phase_reg)
                    PH_START: begin
                        if (sub_reg == 2'd0) begin
                            data_pin_next = 1'b0;
                            sub_next      = 2'd1;
                        end else begin
                            clock_pin_next  = 1'b0;
                            phase_next      = PH_BYTE;
                            sub_next        = 2'd0;
                            bit_next        = 3'd0;
                            byte_index_next = 3'd0;
                        end
                    end
                    PH_BYTE: begin
                        if (sub_reg == 2'd0) begin
                            data_pin_next = cur_byte[bit_reg];
                            sub_next      = 2'd1;
                        end else if (sub_reg == 2'd1) begin
                            clock_pin_next = 1'b1;
                            sub_next       = 2'd2;
                        end else begin
                            clock_pin_next = 1'b0;
                            sub_next       = 2'd0;
                            if (bit_reg == 3'd7) begin
                                phase_next = PH_ACK;
                            end
                            bit_next = bit_reg + 3'd1;
                        end
                    end
                    PH_ACK: begin
                        if (sub_reg == 2'd0) begin
                            clock_pin_next = 1'b0;
                            sub_next       = 2'd1;
                        end else if (sub_reg == 2'd1) begin
                            clock_pin_next = 1'b1;
                            sub_next       = 2'd2;
                        end else begin
                            clock_pin_next  = 1'b0;
                            sub_next        = 2'd0;
                            bit_next        = 3'd0;
                            byte_index_next = byte_inc;
                            if (byte_inc >= frame_len_reg[frame_index_reg]) begin
                                phase_next = PH_STOP;
                            end else begin
                                phase_next = PH_BYTE;
                            end
                        end
                    end
                    default: begin
                        if (sub_reg == 2'd0) begin
                            data_pin_next = 1'b0;
                            sub_next      = 2'd1;
                        end else if (sub_reg == 2'd1) begin
                            clock_pin_next = 1'b1;
                            sub_next       = 2'd2;
                        end else begin
                            data_pin_next   = 1'b1;
                            phase_next      = PH_START;
                            sub_next        = 2'd0;
                            bit_next        = 3'd0;
                            byte_index_next = 3'd0;
                            // skip empty frames, finish after the last one
                            if (frame_index_reg == 2'd0 && frame_len_reg[1] != 3'd0) begin
                                frame_index_next = 2'd1;
                            end else if (frame_index_reg != 2'd2
                                         && frame_len_reg[2] != 3'd0) begin
                                frame_index_next = 2'd2;
                            end else begin
                                frame_index_next = 2'd0;
                                active_next      = 1'b0;
                            end
                        end
                    end
                endcase
            end
        end else if (is_request) begin
            if (active_reg) begin
                rejected_next = 1'b1;
            end else begin
                store_we = 1'b1;
                if (req_type == REQ_RAW || req_type == REQ_CHAR) begin
                    byte_store_next[0] = CMD_DATA_FIXED;
                    byte_store_next[1] = CMD_ADDR | {5'd0, position};
                    byte_store_next[2] = (req_type == REQ_RAW) ? raw_segments : char_seg;
                    frame_len_next[0]  = 3'd1;
                    frame_len_next[1]  = 3'd2;
                    frame_len_next[2]  = 3'd1;
                end else if (req_type == REQ_SHOW) begin
                    byte_store_next[0] = CMD_DATA_AUTO;
                    byte_store_next[1] = CMD_ADDR;
                    for (int i = 0; i < SHOWN_DIGITS; i++) begin
                        if (i < 4) begin
                            byte_store_next[3'(i + 2)] = encode_ascii(chars[i % 4])
                                | ((i == 1 && colon_on) ? SEG_DOT : 8'h00);
                        end else begin
                            byte_store_next[3'(i + 2)] = SEG_TABLE[SEG_BLANK];
                        end
                    end
                    frame_len_next[0] = 3'd1;
                    frame_len_next[1] = 3'(SHOWN_DIGITS + 1);
                    frame_len_next[2] = 3'd1;
                end else begin
                    byte_store_next[0] = CMD_DATA_AUTO;
                    frame_len_next[0]  = 3'd1;
                    frame_len_next[1]  = 3'd0;
                    frame_len_next[2]  = 3'd1;
                end
                active_next      = 1'b1;
                phase_next       = PH_START;
                sub_next         = 2'd0;
                bit_next         = 3'd0;
                byte_index_next  = 3'd0;
                frame_index_next = 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg  <= BRIGHTNESS_RESET;
            clock_pin_reg   <= 1'b0;
            data_pin_reg    <= 1'b0;
            active_reg      <= 1'b0;
            frame_index_reg <= 2'd0;
            byte_index_reg  <= 3'd0;
            bit_reg         <= 3'd0;
            sub_reg         <= 2'd0;
            phase_reg       <= PH_START;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                brightness_reg <= cfg_wdata;
            end
            if (s_accept) begin
                clock_pin_reg   <= clock_pin_next;
                data_pin_reg    <= data_pin_next;
                active_reg      <= active_next;
                frame_index_reg <= frame_index_next;
                byte_index_reg  <= byte_index_next;
                bit_reg         <= bit_next;
                sub_reg         <= sub_next;
                phase_reg       <= phase_next;
                m_tvalid_reg    <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            result_reg <= {rejected_next, active_next, data_pin_next, clock_pin_next};
            if (store_we) begin
                byte_store_reg <= byte_store_next;
                frame_len_reg  <= frame_len_next;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, result_reg};

    // A rejected request never ends a running sequence
    a_reject_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && result_reg[3] |-> result_reg[2] && active_reg)
        else $error("rejected result without busy");

    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> (phase_reg == PH_START) && (sub_reg == 2'd0)
                        && (frame_index_reg == 2'd0))
        else $error("idle sequencer not parked");

    a_sub_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sub_reg != 2'd3)
        else $error("step counter out of range");

    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && is_request && !active_reg |=> active_reg && (phase_reg == PH_START))
        else $error("request did not start a sequence");

    a_end_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(active_reg) |-> $past(phase_reg) == PH_STOP && data_pin_reg)
        else $error("sequence ended outside stop condition");

endmodule
